// ===== hdl/svpwm_pkg.sv =====
// Shared constants for the space-vector PWM duty calculator.
// Field widths, register indexes and sector codes; no dependencies.
`default_nettype none

package svpwm_pkg;

   localparam int VOLT_W   = 16;
   localparam int DUTY_W   = 16;
   localparam int SECTOR_W = 3;
   localparam int PERIOD_W = 14;
   localparam int SQRT3_W  = 15;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] REG_PWM_PERIOD        = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_PERIOD_TIMES_SQRT3 = 2'd1;

   localparam logic [PERIOD_W-1:0] PWM_PERIOD_RESET = 14'd14400;
   localparam logic [SQRT3_W-1:0]  SQRT3_RESET      = 15'd24941;

   // Sector codes, 0 stands for sector one.
   localparam logic [SECTOR_W-1:0] SECTOR_ONE   = 3'd0;
   localparam logic [SECTOR_W-1:0] SECTOR_TWO   = 3'd1;
   localparam logic [SECTOR_W-1:0] SECTOR_THREE = 3'd2;
   localparam logic [SECTOR_W-1:0] SECTOR_FOUR  = 3'd3;
   localparam logic [SECTOR_W-1:0] SECTOR_FIVE  = 3'd4;
   localparam logic [SECTOR_W-1:0] SECTOR_SIX   = 3'd5;

   // Final quotient shifts: divide by 131072, and by 2 * 131072 for the base term.
   localparam int DIV_SHIFT      = 17;
   localparam int HALF_DIV_SHIFT = 18;
   localparam int OFFSET_SHIFT   = 3;

endpackage

`default_nettype wire

// ===== hdl/svpwm_ifs.sv =====
// Valid/ready channel interfaces for the duty calculator: command, result
// and register write. Depends on svpwm_pkg for field widths.
`default_nettype none

interface svpwm_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [svpwm_pkg::VOLT_W-1:0] v_alpha;
   logic signed [svpwm_pkg::VOLT_W-1:0] v_beta;

   modport source (output valid, v_alpha, v_beta, input ready);
   modport sink   (input valid, v_alpha, v_beta, output ready);
endinterface

interface svpwm_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [svpwm_pkg::DUTY_W-1:0]      duty_a;
   logic [svpwm_pkg::DUTY_W-1:0]      duty_b;
   logic [svpwm_pkg::DUTY_W-1:0]      duty_c;
   logic [svpwm_pkg::SECTOR_W-1:0]    sector;

   modport source (output valid, duty_a, duty_b, duty_c, sector, input ready);
   modport sink   (input valid, duty_a, duty_b, duty_c, sector, output ready);
endinterface

interface svpwm_csr_if;
   logic                              valid;
   logic                              ready;
   logic [svpwm_pkg::CSR_INDEX_W-1:0] index;
   logic [svpwm_pkg::CSR_DATA_W-1:0]  wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface

`default_nettype wire

// ===== hdl/svpwm_sector_duty_calc.sv =====
// Throughput: one command per cycle; each of the four stages holds its item
// while the stage after it is full, so a stalled result backs up stage by stage.
// The two multipliers in the first stage set the cycle time.
// Reset (synchronous, active high) empties the pipeline and loads the register
// defaults; register writes are always taken and land in the next cycle.
`default_nettype none

module svpwm_sector_duty_calc (
   input  wire            clock,
   input  wire            reset,
   svpwm_req_if.sink      req,
   svpwm_rsp_if.source    rsp,
   svpwm_csr_if.sink      csr
);

   localparam int PROD_W = 32;
   localparam int WIDE_W = 34;

   // Truncating division of a signed value by 2**sh, keeping the low duty bits.
   function automatic logic [svpwm_pkg::DUTY_W-1:0] trunc_shr(
      input logic signed [WIDE_W-1:0] v,
      input int                       sh
   );
      logic signed [WIDE_W-1:0] bias;
      logic signed [WIDE_W-1:0] r;
      bias = (WIDE_W'(1) <<< sh) - WIDE_W'(1);
      r    = (v + (v[WIDE_W-1] ? bias : '0)) >>> sh;
      return r[svpwm_pkg::DUTY_W-1:0];
   endfunction

   // Configuration registers.
   logic [svpwm_pkg::PERIOD_W-1:0] period_ff;
   logic [svpwm_pkg::SQRT3_W-1:0]  sqrt3_ff;

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= svpwm_pkg::PWM_PERIOD_RESET;
         sqrt3_ff  <= svpwm_pkg::SQRT3_RESET;
      end else if (csr.valid) begin
         case (csr.index)
            svpwm_pkg::REG_PWM_PERIOD: begin
               period_ff <= csr.wdata[svpwm_pkg::PERIOD_W-1:0];
            end
            svpwm_pkg::REG_PERIOD_TIMES_SQRT3: begin
               sqrt3_ff <= csr.wdata[svpwm_pkg::SQRT3_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Stage handshake: a stage loads when it is empty or the next one moves on.
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic rdy1, rdy2, rdy3, rdy4;

   assign rdy4      = !v4_ff || rsp.ready;
   assign rdy3      = !v3_ff || rdy4;
   assign rdy2      = !v2_ff || rdy3;
   assign rdy1      = !v1_ff || rdy2;
   assign req.ready = rdy1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req.valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
      end
   end

   // Stage 1: alpha and beta gains.
   logic signed [PROD_W-1:0] ua_in, ub_in, ua_ff, ub_ff;

   assign ua_in = PROD_W'(req.v_alpha * $signed({1'b0, sqrt3_ff}));
   assign ub_in = PROD_W'(req.v_beta * $signed({1'b0, period_ff}));

   always_ff @(posedge clock) begin
      if (rdy1) begin
         ua_ff <= ua_in;
         ub_ff <= ub_in;
      end
   end

   // Stage 2: X, Y and Z; the halving rounds toward zero.
   logic signed [PROD_W-1:0] x_in, sum_y, sum_z, y_in, z_in;
   logic signed [PROD_W-1:0] x_ff, y_ff, z_ff;

   assign x_in  = -ub_ff;
   assign sum_y = x_in + ua_ff;
   assign sum_z = x_in - ua_ff;
   assign y_in  = (sum_y + $signed(PROD_W'(sum_y[PROD_W-1]))) >>> 1;
   assign z_in  = (sum_z + $signed(PROD_W'(sum_z[PROD_W-1]))) >>> 1;

   always_ff @(posedge clock) begin
      if (rdy2) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

   // Stage 3: sector choice and the quotients by 131072 and 262144.
   logic [svpwm_pkg::SECTOR_W-1:0] sector_in, sector_ff;
   logic signed [WIDE_W-1:0]       xw, yw, zw, tw, base_sum;
   logic                           x_pos;
   logic [svpwm_pkg::DUTY_W-1:0]   q_ff, dx_ff, dy_ff, dz_ff;

   assign xw    = WIDE_W'(x_ff);
   assign yw    = WIDE_W'(y_ff);
   assign zw    = WIDE_W'(z_ff);
   assign tw    = $signed({{(WIDE_W - svpwm_pkg::PERIOD_W){1'b0}}, period_ff});
   assign x_pos = !x_ff[PROD_W-1] && (x_ff != '0);

   always_comb begin
      if (y_ff[PROD_W-1]) begin
         if (z_ff[PROD_W-1]) sector_in = svpwm_pkg::SECTOR_FIVE;
         else if (!x_pos)    sector_in = svpwm_pkg::SECTOR_FOUR;
         else                sector_in = svpwm_pkg::SECTOR_THREE;
      end else begin
         if (!z_ff[PROD_W-1]) sector_in = svpwm_pkg::SECTOR_TWO;
         else if (!x_pos)     sector_in = svpwm_pkg::SECTOR_SIX;
         else                 sector_in = svpwm_pkg::SECTOR_ONE;
      end
   end

   always_comb begin
      case (sector_in)
         svpwm_pkg::SECTOR_ONE, svpwm_pkg::SECTOR_FOUR: base_sum = tw + xw - zw;
         svpwm_pkg::SECTOR_TWO, svpwm_pkg::SECTOR_FIVE: base_sum = tw + yw - zw;
         default:                                       base_sum = tw - xw + yw;
      endcase
   end

   always_ff @(posedge clock) begin
      if (rdy3) begin
         sector_ff <= sector_in;
         q_ff      <= trunc_shr(base_sum, svpwm_pkg::HALF_DIV_SHIFT);
         dx_ff     <= trunc_shr(xw, svpwm_pkg::DIV_SHIFT);
         dy_ff     <= trunc_shr(yw, svpwm_pkg::DIV_SHIFT);
         dz_ff     <= trunc_shr(zw, svpwm_pkg::DIV_SHIFT);
      end
   end

   // Stage 4: compares, all modulo 65536.
   logic [svpwm_pkg::DUTY_W-1:0] duty_a_in, duty_b_in, duty_c_in;
   logic [svpwm_pkg::DUTY_W-1:0] duty_a_ff, duty_b_ff, duty_c_ff;
   logic [svpwm_pkg::SECTOR_W-1:0] sector_out_ff;

   always_comb begin
      duty_a_in = svpwm_pkg::DUTY_W'(period_ff >> svpwm_pkg::OFFSET_SHIFT) + q_ff;
      case (sector_ff)
         svpwm_pkg::SECTOR_ONE, svpwm_pkg::SECTOR_FOUR: begin
            duty_b_in = duty_a_in + dz_ff;
            duty_c_in = duty_b_in - dx_ff;
         end
         svpwm_pkg::SECTOR_TWO, svpwm_pkg::SECTOR_FIVE: begin
            duty_b_in = duty_a_in + dz_ff;
            duty_c_in = duty_a_in - dy_ff;
         end
         default: begin
            duty_c_in = duty_a_in - dy_ff;
            duty_b_in = duty_c_in + dx_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (rdy4) begin
         duty_a_ff     <= duty_a_in;
         duty_b_ff     <= duty_b_in;
         duty_c_ff     <= duty_c_in;
         sector_out_ff <= sector_ff;
      end
   end

   assign rsp.valid  = v4_ff;
   assign rsp.duty_a = duty_a_ff;
   assign rsp.duty_b = duty_b_ff;
   assign rsp.duty_c = duty_c_ff;
   assign rsp.sector = sector_out_ff;

endmodule

`default_nettype wire

// ===== hdl/svpwm_checker.sv =====
// Port-level checks for the duty calculator, bound to the top level.
// Depends on svpwm_pkg for widths and sector codes.
`default_nettype none

module svpwm_checker (
   input wire                              clock,
   input wire                              reset,
   input wire                              csr_valid,
   input wire                              csr_ready,
   input wire                              rsp_valid,
   input wire                              rsp_ready,
   input wire [svpwm_pkg::DUTY_W-1:0]      rsp_duty_a,
   input wire [svpwm_pkg::DUTY_W-1:0]      rsp_duty_b,
   input wire [svpwm_pkg::DUTY_W-1:0]      rsp_duty_c,
   input wire [svpwm_pkg::SECTOR_W-1:0]    rsp_sector
);

   // A result that waits keeps its valid.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result valid dropped before its transfer");

   // A result that waits keeps its payload.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_duty_a) && $stable(rsp_duty_b)
                                  && $stable(rsp_duty_c) && $stable(rsp_sector))
      else $error("result payload changed while stalled");

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Only six sector codes exist.
   a_sector_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_sector <= svpwm_pkg::SECTOR_SIX)
      else $error("sector code out of range");

   // Register writes never stall.
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("register write stalled");

endmodule

bind svpwm_sector_duty_calc svpwm_checker u_svpwm_checker (
   .clock      (clock),
   .reset      (reset),
   .csr_valid  (csr.valid),
   .csr_ready  (csr.ready),
   .rsp_valid  (rsp.valid),
   .rsp_ready  (rsp.ready),
   .rsp_duty_a (rsp.duty_a),
   .rsp_duty_b (rsp.duty_b),
   .rsp_duty_c (rsp.duty_c),
   .rsp_sector (rsp.sector)
);

`default_nettype wire

// ===== dv/svpwm_sector_duty_calc_tb.sv =====
// Self-checking testbench for svpwm_sector_duty_calc: directed and random voltage
// commands over several register settings, checked against an in-bench predictor.
// Depends on svpwm_pkg and the channel interfaces in svpwm_ifs.
module svpwm_sector_duty_calc_tb;

   localparam int     PIPE_LATENCY    = 4;
   localparam int     CYCLE_LIMIT     = 600000;
   localparam int     RANDOM_PHASES   = 6;
   localparam int     ITEMS_PER_PHASE = 172;
   localparam int     MAX_REPORTS     = 10;
   localparam longint QUOT_DIVISOR    = longint'(1) << svpwm_pkg::DIV_SHIFT;

   // Indexes that decode to no register; writes there must change nothing.
   localparam logic [svpwm_pkg::CSR_INDEX_W-1:0] REG_UNUSED_2 = 2'd2;
   localparam logic [svpwm_pkg::CSR_INDEX_W-1:0] REG_UNUSED_3 = 2'd3;

   typedef struct packed {
      logic [svpwm_pkg::DUTY_W-1:0]   duty_a;
      logic [svpwm_pkg::DUTY_W-1:0]   duty_b;
      logic [svpwm_pkg::DUTY_W-1:0]   duty_c;
      logic [svpwm_pkg::SECTOR_W-1:0] sector;
   } duty_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic [svpwm_pkg::PERIOD_W-1:0] period_reg;
   logic [svpwm_pkg::SQRT3_W-1:0]  gain_reg;
   duty_result_type                pending_duties[$];
   int                             mismatch_count = 0;
   bit                             sender_idles = 1'b1;

   svpwm_req_if req_if ();
   svpwm_rsp_if rsp_if ();
   svpwm_csr_if csr_if ();

   svpwm_sector_duty_calc dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if),
      .csr   (csr_if)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Divisions are on signed longints, so they truncate toward zero like the hardware does.
   function automatic duty_result_type predict_duties(
      input logic signed [svpwm_pkg::VOLT_W-1:0] va,
      input logic signed [svpwm_pkg::VOLT_W-1:0] vb);
      longint                         t, ua, ub, x, y, z, a, b, c;
      logic [svpwm_pkg::SECTOR_W-1:0] sec;
      duty_result_type                r;
      t  = longint'(period_reg);
      ua = longint'(va) * longint'(gain_reg);
      ub = -(longint'(vb) * t);
      x  = ub;
      y  = (ub + ua) / 2;
      z  = (ub - ua) / 2;
      if (y < 0) begin
         if (z < 0) sec = svpwm_pkg::SECTOR_FIVE;
         else if (x <= 0) sec = svpwm_pkg::SECTOR_FOUR;
         else sec = svpwm_pkg::SECTOR_THREE;
      end else begin
         if (z >= 0) sec = svpwm_pkg::SECTOR_TWO;
         else if (x <= 0) sec = svpwm_pkg::SECTOR_SIX;
         else sec = svpwm_pkg::SECTOR_ONE;
      end
      case (sec)
         svpwm_pkg::SECTOR_ONE, svpwm_pkg::SECTOR_FOUR: begin
            a = t / 8 + ((t + x - z) / 2) / QUOT_DIVISOR;
            b = a + z / QUOT_DIVISOR;
            c = b - x / QUOT_DIVISOR;
         end
         svpwm_pkg::SECTOR_TWO, svpwm_pkg::SECTOR_FIVE: begin
            a = t / 8 + ((t + y - z) / 2) / QUOT_DIVISOR;
            b = a + z / QUOT_DIVISOR;
            c = a - y / QUOT_DIVISOR;
         end
         default: begin
            a = t / 8 + ((t - x + y) / 2) / QUOT_DIVISOR;
            c = a - y / QUOT_DIVISOR;
            b = c + x / QUOT_DIVISOR;
         end
      endcase
      r.duty_a = a[svpwm_pkg::DUTY_W-1:0];
      r.duty_b = b[svpwm_pkg::DUTY_W-1:0];
      r.duty_c = c[svpwm_pkg::DUTY_W-1:0];
      r.sector = sec;
      return r;
   endfunction

   // Mostly short idle stretches, now and then a long one.
   function automatic int idle_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 80) return $urandom_range(1, 3);
      else if (roll < 95) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic signed [svpwm_pkg::VOLT_W-1:0] random_volt();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 20) return svpwm_pkg::VOLT_W'($urandom_range(0, 16) - 8);
      if (roll < 30) begin
         case ($urandom_range(0, 3))
            0: return 16'h8000;
            1: return 16'hFFFF;
            2: return 16'h0000;
            default: return 16'h7FFF;
         endcase
      end
      return svpwm_pkg::VOLT_W'($urandom);
   endfunction

   // Leaves valid high on return so back-to-back commands go out with no idle gap.
   task automatic send_command(input logic signed [svpwm_pkg::VOLT_W-1:0] va,
                               input logic signed [svpwm_pkg::VOLT_W-1:0] vb);
      int gap;
      gap = (sender_idles && $urandom_range(0, 99) >= 60) ? idle_length() : 0;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.v_alpha <= va;
      req_if.v_beta  <= vb;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      pending_duties.push_back(predict_duties(va, vb));
   endtask

   task automatic hold_until_drained();
      req_if.valid <= 1'b0;
      while (pending_duties.size() != 0) @(posedge clock);
   endtask

   task automatic wait_idle();
      hold_until_drained();
      repeat (PIPE_LATENCY + 2) @(posedge clock);
   endtask

   task automatic write_register(input logic [svpwm_pkg::CSR_INDEX_W-1:0] idx,
                                 input logic [svpwm_pkg::CSR_DATA_W-1:0]  data);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.wdata <= data;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      case (idx)
         svpwm_pkg::REG_PWM_PERIOD:
            period_reg = data[svpwm_pkg::PERIOD_W-1:0];
         svpwm_pkg::REG_PERIOD_TIMES_SQRT3:
            gain_reg   = data[svpwm_pkg::SQRT3_W-1:0];
         default: ;
      endcase
   endtask

   task automatic program_gains(input logic [svpwm_pkg::CSR_DATA_W-1:0] period_data,
                                input logic [svpwm_pkg::CSR_DATA_W-1:0] gain_data);
      write_register(svpwm_pkg::REG_PWM_PERIOD, period_data);
      write_register(svpwm_pkg::REG_PERIOD_TIMES_SQRT3, gain_data);
      csr_if.valid <= 1'b0;
   endtask

   // Field extremes and one vector in the middle of each sector, at reset gains.
   task automatic test_reset_defaults();
      int pairs[17][2] = '{
         '{0, 0}, '{32767, 32767}, '{-32768, -32768}, '{32767, -32768},
         '{-32768, 32767}, '{32767, 0}, '{-32768, 0}, '{0, 32767}, '{0, -32768},
         '{-1, -1}, '{1, 1},
         '{13856, 8000}, '{0, 16000}, '{-13856, 8000},
         '{-13856, -8000}, '{0, -16000}, '{13856, -8000}
      };
      foreach (pairs[i])
         send_command(svpwm_pkg::VOLT_W'(pairs[i][0]), svpwm_pkg::VOLT_W'(pairs[i][1]));
      wait_idle();
   endtask

   // Unused indexes, masking of wide write data, zero gains and unit gains where
   // the halving of Y and Z truncates to zero.
   task automatic test_register_writes();
      write_register(REG_UNUSED_2, 16'hFFFF);
      write_register(REG_UNUSED_3, 16'h0000);
      program_gains(16'hFFFF, 16'hFFFF);
      send_command(16'h7FFF, 16'h8000);
      send_command(16'h8000, 16'h7FFF);
      send_command(16'h7FFF, 16'h7FFF);
      wait_idle();
      program_gains(16'h0000, 16'h0000);
      send_command(16'h1234, -16'sd5);
      wait_idle();
      program_gains(16'd1, 16'd1);
      send_command(16'sd0, 16'sd1);
      send_command(16'sd1, 16'sd0);
      send_command(-16'sd1, 16'sd1);
      wait_idle();
   endtask

   task automatic test_random_phases();
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: program_gains(svpwm_pkg::CSR_DATA_W'(svpwm_pkg::PWM_PERIOD_RESET),
                             svpwm_pkg::CSR_DATA_W'(svpwm_pkg::SQRT3_RESET));
            1: program_gains(16'd16383, 16'd28377);
            2: program_gains(svpwm_pkg::CSR_DATA_W'($urandom),
                             svpwm_pkg::CSR_DATA_W'($urandom));
            3: program_gains(svpwm_pkg::CSR_DATA_W'($urandom_range(1, 15)),
                             svpwm_pkg::CSR_DATA_W'($urandom_range(1, 15)));
            4: program_gains(svpwm_pkg::CSR_DATA_W'($urandom_range(0, 16383)),
                             svpwm_pkg::CSR_DATA_W'($urandom_range(0, 28377)));
            default: program_gains(16'd16383, 16'd0);
         endcase
         sender_idles = (phase % 3 != 1);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            send_command(random_volt(), random_volt());
            if ($urandom_range(0, 63) == 0) hold_until_drained();
         end
         wait_idle();
      end
      sender_idles = 1'b1;
   endtask

   // Result sink: random stalls, with windows where ready stays high.
   initial begin
      int stall_left;
      int window_left;
      bit stalls_on;
      stall_left    = 0;
      window_left   = 0;
      stalls_on     = 1'b1;
      rsp_if.ready  = 1'b0;
      forever begin
         @(posedge clock);
         if (window_left == 0) begin
            stalls_on   = ($urandom_range(0, 3) != 0);
            window_left = $urandom_range(50, 300);
         end else begin
            window_left--;
         end
         if (stalls_on && stall_left == 0 && $urandom_range(0, 3) == 0)
            stall_left = idle_length();
         if (stall_left > 0) begin
            rsp_if.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      duty_result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_duties.size() == 0) begin
            if (mismatch_count < MAX_REPORTS)
               $display("%0t: result with nothing expected: a=%h b=%h c=%h sector=%0d",
                        $realtime, rsp_if.duty_a, rsp_if.duty_b, rsp_if.duty_c,
                        rsp_if.sector);
            mismatch_count++;
         end else begin
            want = pending_duties.pop_front();
            if (rsp_if.duty_a !== want.duty_a || rsp_if.duty_b !== want.duty_b ||
                rsp_if.duty_c !== want.duty_c || rsp_if.sector !== want.sector) begin
               if (mismatch_count < MAX_REPORTS)
                  $display("%0t: expected a=%h b=%h c=%h sector=%0d, got a=%h b=%h c=%h sector=%0d",
                           $realtime, want.duty_a, want.duty_b, want.duty_c, want.sector,
                           rsp_if.duty_a, rsp_if.duty_b, rsp_if.duty_c, rsp_if.sector);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("svpwm_sector_duty_calc: mismatch");
      $finish;
   end

   initial begin
      req_if.valid   <= 1'b0;
      req_if.v_alpha <= '0;
      req_if.v_beta  <= '0;
      csr_if.valid   <= 1'b0;
      csr_if.index   <= svpwm_pkg::REG_PWM_PERIOD;
      csr_if.wdata   <= '0;
      period_reg = svpwm_pkg::PWM_PERIOD_RESET;
      gain_reg   = svpwm_pkg::SQRT3_RESET;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_register_writes();
      test_random_phases();
      hold_until_drained();
      repeat (PIPE_LATENCY * 4) @(posedge clock);
      if (mismatch_count == 0 && pending_duties.size() == 0)
         $display("svpwm_sector_duty_calc: match");
      else
         $display("svpwm_sector_duty_calc: mismatch");
      $finish;
   end

endmodule
